/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is disabled while reset is asserted.
`define RDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication that is disabled while reset is asserted.
`define RDQ_ASSERT_IMP(lbl, ante, cons, msg) \
	`RDQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/rdq_pkg.sv */
// ----------------------------------------------------------------------------
// Ring deque package
// Operation and status codes and the result record shared by the deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

	localparam int ENTRY_IO_W = 8;
	localparam int OCC_W      = 6;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP        = 2'd2,
		OP_PEEK       = 2'd3
	} rdq_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} rdq_status_t;

	typedef struct packed {
		logic              entry_valid;
		rdq_status_t       status;
		logic [OCC_W-1:0]  occupancy;
	} rdq_res_t;

endpackage

`default_nettype wire

/* rtl/rdq_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one deque request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] entry_in;

	modport source (output valid, output opcode, output entry_in, input ready);
	modport sink (input valid, input opcode, input entry_in, output ready);
endinterface

`default_nettype wire

/* rtl/rdq_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one deque result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] entry_out;
	logic       entry_valid;
	logic [1:0] status;
	logic [5:0] occupancy;

	modport source (output valid, output entry_out, output entry_valid, output status,
		output occupancy, input ready);
	modport sink (input valid, input entry_out, input entry_valid, input status,
		input occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/ring_deque_push_front_back.sv */
// Path: an accepted request passes the first stage, then the output register.
// Throughput: one request per cycle unless the result stalls; each request
// writes or reads a slot at most once; head and count update on acceptance.
// Reset: asynchronous, clears head, count and both stage valid flags.
// The slot memory is not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
// Ring deque top level
// Double-ended ring queue with push back, push front, pop and peek.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_push_front_back
	import rdq_pkg::*;
#(
	parameter int DEPTH       = 32,
	parameter int ENTRY_WIDTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rdq_req_if.sink    req,
	rdq_rsp_if.source  rsp
);

	logic                   valid_s1;
	rdq_res_t               res_s1;
	logic [ENTRY_WIDTH-1:0] rdata;
	logic                   advance;
	logic                   accept;
	logic                   out_valid_q;
	logic [ENTRY_IO_W-1:0]  entry_out_q;
	rdq_res_t               res_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	rdq_ctrl #(
		.DEPTH       (DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (req.opcode),
		.entry_in (req.entry_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.res_s1   (res_s1),
		.rdata    (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q       <= res_s1;
			entry_out_q <= res_s1.entry_valid ? ENTRY_IO_W'(rdata) : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry_out   = entry_out_q;
	assign rsp.entry_valid = res_q.entry_valid;
	assign rsp.status      = res_q.status;
	assign rsp.occupancy   = res_q.occupancy;

endmodule

`default_nettype wire

/* rtl/rdq_ram.sv */
// ----------------------------------------------------------------------------
// Ring deque slot memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdq_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/rdq_ctrl.sv */
// ----------------------------------------------------------------------------
// Ring deque control
// Keeps head and count, drives the slot memory and holds the first stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdq_ctrl
	import rdq_pkg::*;
#(
	parameter int DEPTH       = 32,
	parameter int ENTRY_WIDTH = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [1:0]             opcode,
	input  wire logic [ENTRY_IO_W-1:0]  entry_in,
	input  wire logic                   advance,
	output      logic                   valid_s1,
	output      rdq_res_t               res_s1,
	output      logic [ENTRY_WIDTH-1:0] rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_dec;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail;
	logic          full;
	logic          empty;
	logic          is_push;
	logic          push_ok;
	logic          read_ok;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;
	rdq_res_t      res_d;

	always_comb begin
		full     = (count_q == CW'(DEPTH));
		empty    = (count_q == '0);
		is_push  = (opcode == OP_PUSH_BACK) || (opcode == OP_PUSH_FRONT);
		head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
		tail_sum = SW'(head_q) + SW'(count_q);
		tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
		push_ok  = accept && is_push && !full;
		read_ok  = accept && !is_push && !empty;
		we       = push_ok;
		waddr    = (opcode == OP_PUSH_BACK) ? tail : head_dec;
		head_d   = head_q;
		count_d  = count_q;
		if (push_ok) begin
			count_d = count_q + CW'(1);
			if (opcode == OP_PUSH_FRONT) begin
				head_d = head_dec;
			end
		end else if (read_ok && (opcode == OP_POP)) begin
			count_d = count_q - CW'(1);
			head_d  = head_inc;
		end
		res_d.entry_valid = !is_push && !empty;
		if (is_push && full) begin
			res_d.status = ST_OVERFLOW;
		end else if (!is_push && empty) begin
			res_d.status = ST_EMPTY;
		end else begin
			res_d.status = ST_OK;
		end
		res_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	rdq_ram #(
		.DEPTH(DEPTH),
		.WIDTH(ENTRY_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ENTRY_WIDTH'(entry_in)),
		.re    (read_ok),
		.raddr (head_q),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

/* rtl/rdq_checker.sv */
// ----------------------------------------------------------------------------
// Ring deque checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rdq_checker
	import rdq_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  rsp_valid,
	input wire logic                  rsp_ready,
	input wire logic [ENTRY_IO_W-1:0] entry_out,
	input wire logic                  entry_valid,
	input wire logic [1:0]            status,
	input wire logic [OCC_W-1:0]      occupancy
);

	`RDQ_ASSERT_IMP(a_rsp_hold, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(entry_out) && $stable(status) && $stable(occupancy)), "Stalled result changed.")
	`RDQ_ASSERT_IMP(a_overflow_fields, rsp_valid && (status == ST_OVERFLOW), !entry_valid && (entry_out == '0) && (occupancy == OCC_W'(DEPTH)), "Overflow result is inconsistent.")
	`RDQ_ASSERT_IMP(a_empty_fields, rsp_valid && (status == ST_EMPTY), !entry_valid && (entry_out == '0) && (occupancy == '0), "Empty result is inconsistent.")
	`RDQ_ASSERT_IMP(a_invalid_zero, rsp_valid && !entry_valid, entry_out == '0, "Entry without valid flag is not zero.")

endmodule

bind ring_deque_push_front_back rdq_checker #(
	.DEPTH(DEPTH)
) u_rdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.entry_out   (rsp.entry_out),
	.entry_valid (rsp.entry_valid),
	.status      (rsp.status),
	.occupancy   (rsp.occupancy)
);

`default_nettype wire
